@@ rtl/bma_pkg.sv @@
`default_nettype none

package bma_pkg;

    localparam int TIME_W          = 32;
    localparam int LEVEL_W         = 7;
    localparam int DIGIT_W         = 2;
    localparam int TIME_DIGITS     = TIME_W / DIGIT_W;
    localparam int WINDOW_SIZE_DEF = 8;

    // input tdata: now_ms, prev_level, sample_percent, zero fill
    localparam int IN_TDATA_W  = ((TIME_W + 2 * LEVEL_W + 7) / 8) * 8;
    // output tdata: level, zero fill
    localparam int OUT_TDATA_W = ((LEVEL_W + 7) / 8) * 8;

    localparam logic [TIME_W-1:0] RESET_INTERVAL_MS = 32'd30000;

    typedef struct packed {
        logic done;
        logic le;
    } cmp_status_t;

    typedef struct packed {
        logic               done;
        logic [LEVEL_W-1:0] quot;
    } div_status_t;

endpackage

`default_nettype wire

@@ rtl/bma_serial_cmp.sv @@
`default_nettype none

module bma_serial_cmp (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [bma_pkg::TIME_W-1:0] now_ms,
    input  wire logic [bma_pkg::TIME_W-1:0] last_ms,
    input  wire logic [bma_pkg::TIME_W-1:0] limit_ms,
    output bma_pkg::cmp_status_t            status
);
    import bma_pkg::*;

    localparam int CNT_W = $clog2(TIME_DIGITS + 1);

    logic [TIME_W-1:0] now_sh_reg,   now_sh_next;
    logic [TIME_W-1:0] last_sh_reg,  last_sh_next;
    logic [TIME_W-1:0] lim_sh_reg,   lim_sh_next;
    logic              borrow_reg,   borrow_next;
    logic              gt_reg,       gt_next;
    logic [CNT_W-1:0]  cnt_reg,      cnt_next;
    logic              busy_reg,     busy_next;
    logic              done_reg,     done_next;

    logic a_bit;
    logic b_bit;
    logic e_bit;

    // elapsed = now - last, LSB first, DIGIT_W bits per cycle;
    // gt tracks elapsed > limit over the bits seen so far
    always_comb
    begin
        now_sh_next  = now_sh_reg;
        last_sh_next = last_sh_reg;
        lim_sh_next  = lim_sh_reg;
        borrow_next  = borrow_reg;
        gt_next      = gt_reg;
        cnt_next     = cnt_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        a_bit        = 1'b0;
        b_bit        = 1'b0;
        e_bit        = 1'b0;
        if (start)
        begin
            now_sh_next  = now_ms;
            last_sh_next = last_ms;
            lim_sh_next  = limit_ms;
            borrow_next  = 1'b0;
            gt_next      = 1'b0;
            cnt_next     = CNT_W'(TIME_DIGITS);
            busy_next    = 1'b1;
        end
        else if (busy_reg)
        begin
            for (int j = 0; j < DIGIT_W; j++)
            begin
                a_bit       = now_sh_reg[j];
                b_bit       = last_sh_reg[j];
                e_bit       = a_bit ^ b_bit ^ borrow_next;
                borrow_next = (~a_bit & b_bit) | (~(a_bit ^ b_bit) & borrow_next);
                if (e_bit != lim_sh_reg[j])
                begin
                    gt_next = e_bit;
                end
            end
            now_sh_next  = now_sh_reg >> DIGIT_W;
            last_sh_next = last_sh_reg >> DIGIT_W;
            lim_sh_next  = lim_sh_reg >> DIGIT_W;
            cnt_next     = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_sh_reg  <= now_sh_next;
        last_sh_reg <= last_sh_next;
        lim_sh_reg  <= lim_sh_next;
        borrow_reg  <= borrow_next;
        gt_reg      <= gt_next;
    end

    assign status.done = done_reg;
    assign status.le   = ~gt_reg;

endmodule

`default_nettype wire

@@ rtl/bma_serial_div.sv @@
`default_nettype none

module bma_serial_div #(
    parameter int SUM_W = 11,
    parameter int DIV_W = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [SUM_W-1:0] dividend,
    input  wire logic [DIV_W-1:0] divisor,
    output bma_pkg::div_status_t  status
);
    import bma_pkg::*;

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0] dvd_reg,  dvd_next;
    logic [SUM_W-1:0] quot_reg, quot_next;
    logic [DIV_W-1:0] rem_reg,  rem_next;
    logic [DIV_W-1:0] dsr_reg,  dsr_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   rem_sh;
    logic [DIV_W:0]   rem_sub;

    // restoring division, one quotient bit per cycle, MSB first
    always_comb
    begin
        dvd_next  = dvd_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg, dvd_reg[SUM_W-1]};
        rem_sub   = rem_sh - {1'b0, dsr_reg};
        if (start)
        begin
            dvd_next  = dividend;
            quot_next = '0;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CNT_W'(SUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = dvd_reg << 1;
            if (rem_sh >= {1'b0, dsr_reg})
            begin
                rem_next  = rem_sub[DIV_W-1:0];
                quot_next = {quot_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[DIV_W-1:0];
                quot_next = {quot_reg[SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign status.done = done_reg;
    assign status.quot = quot_reg[LEVEL_W-1:0];

endmodule

`default_nettype wire

@@ rtl/battery_level_moving_average_top.sv @@
// Battery level smoother with an N-sample moving average and warm-up.
// s_axis carries one request per transaction (now_ms, prev_level,
// sample_percent); m_axis returns one result per request (level in tdata,
// sampled flag in tuser). cfg_valid/cfg_data write min_interval_ms.
// Each request first runs a 2-bit-per-cycle serial subtract and compare
// of the elapsed time against min_interval_ms. A held level then goes to
// the output register. A new sample is written into the ring, the filled
// entries are summed one per cycle and the sum goes through a bit-serial
// divider (one sum bit per cycle; at WINDOW_SIZE = 8 the sum is 10 bits
// wide). One request is in flight at a time; s_axis_tready is high only
// while the block is free. The output register holds a finished result
// while m_axis_tready is low, and the next request may already be
// accepted and worked on meanwhile.
// Reset clears the sample time, write slot and fill count and loads
// min_interval_ms with 30000; ring entries are only read once written.
`default_nettype none

module battery_level_moving_average_top #(
    parameter int WINDOW_SIZE = bma_pkg::WINDOW_SIZE_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output wire logic                            s_axis_tready,
    // now_ms[31:0], prev_level[38:32], sample_percent[45:39], zero fill
    input  wire logic [bma_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output wire logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // level[6:0], zero fill
    output wire logic [bma_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // sampled[0]
    output wire logic [0:0]                      m_axis_tuser,
    input  wire logic                            cfg_valid,
    output wire logic                            cfg_ready,
    input  wire logic [bma_pkg::TIME_W-1:0]      cfg_data
);
    import bma_pkg::*;

    localparam int SLOT_W  = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int COUNT_W = $clog2(WINDOW_SIZE + 1);
    localparam int SUM_W   = $clog2(WINDOW_SIZE * ((1 << LEVEL_W) - 1) + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_SUM,
        S_DIV,
        S_OUT
    } state_t;

    state_t               state_reg,   state_next;
    logic [TIME_W-1:0]    limit_reg,   limit_next;
    logic [TIME_W-1:0]    last_reg,    last_next;
    logic [TIME_W-1:0]    now_reg,     now_next;
    logic [LEVEL_W-1:0]   prev_reg,    prev_next;
    logic [LEVEL_W-1:0]   fresh_reg,   fresh_next;
    logic [SLOT_W-1:0]    slot_reg,    slot_next;
    logic [COUNT_W-1:0]   filled_reg,  filled_next;
    logic [SLOT_W-1:0]    idx_reg,     idx_next;
    logic [SUM_W-1:0]     sum_reg,     sum_next;
    logic [LEVEL_W-1:0]   res_lvl_reg, res_lvl_next;
    logic                 res_smp_reg, res_smp_next;
    logic [LEVEL_W-1:0]   out_lvl_reg, out_lvl_next;
    logic                 out_smp_reg, out_smp_next;
    logic                 m_vld_reg,   m_vld_next;

    logic [LEVEL_W-1:0]   ring [WINDOW_SIZE];
    logic                 ring_we;
    logic                 in_fire;
    logic                 div_start;
    cmp_status_t          cmp_st;
    div_status_t          div_st;

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;

    bma_serial_cmp u_cmp (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_fire),
        .now_ms   (s_axis_tdata[TIME_W-1:0]),
        .last_ms  (last_reg),
        .limit_ms (limit_reg),
        .status   (cmp_st)
    );

    bma_serial_div #(
        .SUM_W (SUM_W),
        .DIV_W (COUNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (filled_reg),
        .status   (div_st)
    );

    always_comb
    begin
        state_next   = state_reg;
        limit_next   = limit_reg;
        last_next    = last_reg;
        now_next     = now_reg;
        prev_next    = prev_reg;
        fresh_next   = fresh_reg;
        slot_next    = slot_reg;
        filled_next  = filled_reg;
        idx_next     = idx_reg;
        sum_next     = sum_reg;
        res_lvl_next = res_lvl_reg;
        res_smp_next = res_smp_reg;
        out_lvl_next = out_lvl_reg;
        out_smp_next = out_smp_reg;
        m_vld_next   = m_vld_reg;
        ring_we      = 1'b0;
        div_start    = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            limit_next = cfg_data;
        end

        if (m_vld_reg && m_axis_tready)
        begin
            m_vld_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    now_next   = s_axis_tdata[TIME_W-1:0];
                    prev_next  = s_axis_tdata[TIME_W+LEVEL_W-1:TIME_W];
                    fresh_next = s_axis_tdata[TIME_W+2*LEVEL_W-1:TIME_W+LEVEL_W];
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (cmp_st.done)
                begin
                    if (prev_reg != '0 && cmp_st.le)
                    begin
                        res_lvl_next = prev_reg;
                        res_smp_next = 1'b0;
                        state_next   = S_OUT;
                    end
                    else
                    begin
                        last_next = now_reg;
                        ring_we   = 1'b1;
                        if (slot_reg == SLOT_W'(WINDOW_SIZE - 1))
                        begin
                            slot_next = '0;
                        end
                        else
                        begin
                            slot_next = slot_reg + SLOT_W'(1);
                        end
                        if (filled_reg != COUNT_W'(WINDOW_SIZE))
                        begin
                            filled_next = filled_reg + COUNT_W'(1);
                        end
                        idx_next   = '0;
                        sum_next   = '0;
                        state_next = S_SUM;
                    end
                end
            end
            S_SUM:
            begin
                sum_next = sum_reg + SUM_W'(ring[idx_reg]);
                idx_next = idx_reg + SLOT_W'(1);
                if (COUNT_W'(idx_reg) + COUNT_W'(1) == filled_reg)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_st.done)
                begin
                    res_lvl_next = div_st.quot;
                    res_smp_next = 1'b1;
                    state_next   = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!m_vld_reg || m_axis_tready)
                begin
                    out_lvl_next = res_lvl_reg;
                    out_smp_next = res_smp_reg;
                    m_vld_next   = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            limit_reg  <= RESET_INTERVAL_MS;
            last_reg   <= '0;
            slot_reg   <= '0;
            filled_reg <= '0;
            m_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            limit_reg  <= limit_next;
            last_reg   <= last_next;
            slot_reg   <= slot_next;
            filled_reg <= filled_next;
            m_vld_reg  <= m_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg     <= now_next;
        prev_reg    <= prev_next;
        fresh_reg   <= fresh_next;
        idx_reg     <= idx_next;
        sum_reg     <= sum_next;
        res_lvl_reg <= res_lvl_next;
        res_smp_reg <= res_smp_next;
        out_lvl_reg <= out_lvl_next;
        out_smp_reg <= out_smp_next;
    end

    // sample ring
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring[slot_reg] <= fresh_reg;
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_vld_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(out_lvl_reg);
    assign m_axis_tuser  = out_smp_reg;

    a_accept_starts_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == S_CMP)
        else $error("accepted transaction did not start the compare");

    a_cmp_done_in_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_st.done |-> state_reg == S_CMP)
        else $error("compare finished outside the compare phase");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_st.done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide phase");

    a_sample_updates_state: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP && cmp_st.done && !(prev_reg != '0 && cmp_st.le))
        |=> (filled_reg != '0 && last_reg == $past(now_reg)))
        else $error("sample taken without updating time or fill count");

    a_sum_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SUM |-> filled_reg != '0 && COUNT_W'(idx_reg) < filled_reg)
        else $error("summing past the filled entries");

endmodule

`default_nettype wire
